[rtl/b64sc_pkg.sv]
// package: payload structs, job record and alphabet helpers for the base64 codec
`default_nettype none
package b64sc_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic       DIR_ENCODE = 1'b0;
   localparam logic       DIR_DECODE = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_data;
      logic       last_of_run;
      logic       message_done;
   } rsp_type;

   // one request's worth of results, chars[0] goes out first
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [2:0]      count;
      logic            marker;
      logic            eom;
   } job_type;

   function automatic logic [7:0] char_of(input logic [5:0] six);
      logic [7:0] c;
      if (six < 6'd26)       c = 8'h41 + {2'b00, six};
      else if (six < 6'd52)  c = 8'h61 + {2'b00, six} - 8'd26;
      else if (six < 6'd62)  c = 8'h30 + {2'b00, six} - 8'd52;
      else if (six == 6'd62) c = 8'h2B;
      else                   c = 8'h2F;
      return c;
   endfunction

   function automatic logic [5:0] symbol_of(input logic [7:0] c);
      logic [7:0] s;
      if (c >= 8'h41 && c <= 8'h5A)      s = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) s = c - 8'h61 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) s = c - 8'h30 + 8'd52;
      else if (c == 8'h2B)               s = 8'd62;
      else if (c == 8'h2F)               s = 8'd63;
      else                               s = 8'd0;
      return s[5:0];
   endfunction

   // bytes given out by a decode group with this many pads
   function automatic logic [2:0] flush_count(input logic [2:0] pads);
      logic [2:0] n;
      if (pads >= 3'd3) n = 3'd0;
      else              n = 3'd3 - pads;
      return n;
   endfunction

endpackage
`default_nettype wire

[rtl/base64_stream_codec.sv]
// top level: base64 encoder / decoder with a job queue between front and back
//
//   channel  ports                       moves
//   req      req_valid req_stall req_*   one byte or character in
//   rsp      rsp_valid rsp_stall rsp_*   one character, byte or end marker out
//   csr      csr_valid csr_ready csr_*   direction register write
//
// a request is taken when the job queue has room; it makes 0 to 4
// results, given out one per cycle while rsp_stall is low from the output register,
// so an encode group of three bytes gives four results at the result port.
// reset clears group state, the queue and the output register; direction is encode.
// rsp_stall holds the result register, the queue fills, then req_stall rises.
`default_nettype none
module base64_stream_codec
   import b64sc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   logic    full, empty, push, pop, accept;
   job_type job, head;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign csr_ready = 1'b1;

   b64sc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .push      (push),
      .job       (job)
   );

   b64sc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   b64sc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

[rtl/b64sc_front.sv]
// front end: accepts requests, keeps group state and builds result jobs
`default_nettype none
module b64sc_front
   import b64sc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   input  wire logic    csr_write,
   input  wire logic    csr_value,
   output logic         push,
   output job_type      job
);

   logic        direction_ff, direction_in;
   logic [23:0] group_ff, group_in;
   logic [1:0]  slot_ff, slot_in;
   logic [2:0]  pad_ff, pad_in;

   logic [23:0] enc_group;
   logic [2:0]  enc_slot;
   logic        is_ws;
   logic [2:0]  dec_pad;
   logic [23:0] dec_group;
   logic [2:0]  dec_slot;
   logic [2:0]  missing;
   logic [2:0]  tail_pads;
   logic [23:0] tail_group;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
         group_ff     <= '0;
         slot_ff      <= '0;
         pad_ff       <= '0;
      end else begin
         direction_ff <= direction_in;
         group_ff     <= group_in;
         slot_ff      <= slot_in;
         pad_ff       <= pad_in;
      end
   end

   always_comb begin
      case (slot_ff)
         2'd0:    enc_group = group_ff | {req.data_byte, 16'h0000};
         2'd1:    enc_group = group_ff | {8'h00, req.data_byte, 8'h00};
         default: enc_group = group_ff | {16'h0000, req.data_byte};
      endcase
      enc_slot  = {1'b0, slot_ff} + 3'd1;
      is_ws     = (req.data_byte == CHAR_CR) || (req.data_byte == CHAR_LF) ||
                  (req.data_byte == CHAR_TAB) || (req.data_byte == CHAR_SP);
      dec_pad   = pad_ff + {2'b00, req.data_byte == PAD_CHAR};
      dec_group = {group_ff[17:0], symbol_of(req.data_byte)};
      dec_slot  = {1'b0, slot_ff} + 3'd1;
   end

   always_comb begin
      direction_in = direction_ff;
      group_in     = group_ff;
      slot_in      = slot_ff;
      pad_in       = pad_ff;
      job          = '0;
      push         = 1'b0;
      missing      = '0;
      tail_pads    = '0;
      tail_group   = '0;
      if (accept) begin
         job.eom = req.end_of_message;
         if (direction_ff == DIR_ENCODE) begin
            if (enc_slot == 3'd3) begin
               job.chars[0] = char_of(enc_group[23:18]);
               job.chars[1] = char_of(enc_group[17:12]);
               job.chars[2] = char_of(enc_group[11:6]);
               job.chars[3] = char_of(enc_group[5:0]);
               job.count    = 3'd4;
               group_in     = '0;
               slot_in      = '0;
            end else begin
               group_in = enc_group;
               slot_in  = enc_slot[1:0];
               if (req.end_of_message) begin
                  job.chars[0] = char_of(enc_group[23:18]);
                  job.chars[1] = char_of(enc_group[17:12]);
                  job.chars[2] = (enc_slot == 3'd2) ? char_of(enc_group[11:6]) : PAD_CHAR;
                  job.chars[3] = PAD_CHAR;
                  job.count    = 3'd4;
               end
            end
         end else begin
            if (!is_ws) begin
               if (dec_slot == 3'd4) begin
                  job.chars[0] = dec_group[23:16];
                  job.chars[1] = dec_group[15:8];
                  job.chars[2] = dec_group[7:0];
                  job.count    = flush_count(dec_pad);
                  group_in     = '0;
                  slot_in      = '0;
                  pad_in       = '0;
               end else begin
                  group_in = dec_group;
                  slot_in  = dec_slot[1:0];
                  pad_in   = dec_pad;
               end
            end
            // short final group: missing symbols act as pads
            if (req.end_of_message && slot_in != 2'd0) begin
               missing   = 3'd4 - {1'b0, slot_in};
               tail_pads = pad_in + missing;
               case (slot_in)
                  2'd1:    tail_group = {group_in[5:0], 18'h00000};
                  2'd2:    tail_group = {group_in[11:0], 12'h000};
                  default: tail_group = {group_in[17:0], 6'h00};
               endcase
               job.chars[0] = tail_group[23:16];
               job.chars[1] = tail_group[15:8];
               job.chars[2] = tail_group[7:0];
               job.count    = flush_count(tail_pads);
            end
         end
         if (req.end_of_message) begin
            group_in = '0;
            slot_in  = '0;
            pad_in   = '0;
            if (job.count == 3'd0) begin
               job.chars  = '0;
               job.count  = 3'd1;
               job.marker = 1'b1;
            end
         end
         push = (job.count != 3'd0);
      end
      if (csr_write) begin
         direction_in = csr_value;
         group_in     = '0;
         slot_in      = '0;
         pad_in       = '0;
      end
   end

endmodule
`default_nettype wire

[rtl/b64sc_queue.sv]
// job queue between the front end and the result serializer
`default_nettype none
module b64sc_queue
   import b64sc_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output job_type      head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       store [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign head    = store[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) store[wr_ptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

[rtl/b64sc_back.sv]
// back end: walks each job and drives one result per cycle, unless stalled, from an output register
`default_nettype none
module b64sc_back
   import b64sc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    empty,
   input  wire job_type head,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       last;

   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      load     = !empty && (!valid_ff || !rsp_stall);
      last     = ({1'b0, idx_ff} == head.count - 3'd1);
      pop      = load && last;
      valid_in = valid_ff;
      out_in   = out_ff;
      idx_in   = idx_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (load) begin
         valid_in            = 1'b1;
         out_in.out_byte     = head.chars[idx_ff];
         out_in.has_data     = !head.marker;
         out_in.last_of_run  = last;
         out_in.message_done = last && head.eom;
         idx_in              = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

[tb/tb_base64_stream_codec.sv]
// testbench for base64_stream_codec: random and directed encode/decode traffic vs a predictor
`timescale 1ns / 1ps
module tb_base64_stream_codec;
   import b64sc_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   base64_stream_codec dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // codec state as the predictor sees it
   logic        dir_mode;
   logic [23:0] grp_bits;
   int          grp_slots;
   int          grp_pads;

   logic [7:0]  step_bytes[$];
   rsp_type     exp_codec_out[$];

   int          error_count = 0;
   int          checked_results = 0;
   int          enc_requests = 0;
   int          dec_requests = 0;
   int          cycle_count = 0;

   bit             gaps_on = 1'b1;
   int             burst_left = 0;
   int             stall_hold = 0;
   int             stall_phase = 0;
   stall_mode_type stall_mode = STALL_NONE;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] b64_char(input logic [5:0] six);
      return b64_alphabet[six];
   endfunction

   function automatic logic [5:0] b64_value(input logic [7:0] c);
      for (int i = 0; i < 64; i++)
         if (b64_alphabet[i] == c) return 6'(i);
      return 6'd0;
   endfunction

   function automatic void clear_group();
      grp_bits  = '0;
      grp_slots = 0;
      grp_pads  = 0;
   endfunction

   function automatic void flush_decoded(input int pads);
      int cnt;
      cnt = (pads >= 3) ? 0 : 3 - pads;
      for (int k = 0; k < cnt; k++)
         step_bytes.push_back(8'(grp_bits >> (16 - 8 * k)));
   endfunction

   // works out the results one accepted request causes
   function automatic void codec_predict(input req_type r);
      logic [7:0] b;
      logic       eom;
      int         missing;
      int         n;
      rsp_type    res;
      b   = r.data_byte;
      eom = r.end_of_message;
      step_bytes.delete();
      if (dir_mode == DIR_ENCODE) begin
         grp_bits = grp_bits | (24'(b) << (16 - 8 * grp_slots));
         grp_slots++;
         if (grp_slots == 3) begin
            for (int k = 0; k < 4; k++)
               step_bytes.push_back(b64_char(6'(grp_bits >> (18 - 6 * k))));
            clear_group();
         end else if (eom) begin
            step_bytes.push_back(b64_char(6'(grp_bits >> 18)));
            step_bytes.push_back(b64_char(6'(grp_bits >> 12)));
            step_bytes.push_back(grp_slots == 2 ? b64_char(6'(grp_bits >> 6)) : PAD_CHAR);
            step_bytes.push_back(PAD_CHAR);
         end
      end else begin
         if (!(b inside {CHAR_CR, CHAR_LF, CHAR_TAB, CHAR_SP})) begin
            if (b == PAD_CHAR) grp_pads++;
            grp_bits = {grp_bits[17:0], b64_value(b)};
            grp_slots++;
            if (grp_slots == 4) begin
               flush_decoded(grp_pads);
               clear_group();
            end
         end
         // a short final group is filled with pads
         if (eom && grp_slots != 0) begin
            missing  = 4 - grp_slots;
            grp_bits = grp_bits << (6 * missing);
            flush_decoded(grp_pads + missing);
         end
      end
      if (eom) clear_group();
      n = step_bytes.size();
      if (n == 0 && eom) begin
         res.out_byte     = 8'h00;
         res.has_data     = 1'b0;
         res.last_of_run  = 1'b1;
         res.message_done = 1'b1;
         exp_codec_out.push_back(res);
      end
      for (int i = 0; i < n; i++) begin
         res.out_byte     = step_bytes[i];
         res.has_data     = 1'b1;
         res.last_of_run  = (i == n - 1);
         res.message_done = eom && (i == n - 1);
         exp_codec_out.push_back(res);
      end
   endfunction

   // sender: bursts of random length separated by random gaps
   task automatic send_item(input logic [7:0] b, input logic eom);
      req_type r;
      if (gaps_on && burst_left == 0) begin
         repeat ($urandom_range(1, 8)) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      end
      if (burst_left > 0) burst_left--;
      r.data_byte      = b;
      r.end_of_message = eom;
      @(negedge clock);
      req_valid   = 1'b1;
      req_payload = r;
      do @(posedge clock); while (req_stall);
      if (dir_mode == DIR_ENCODE) enc_requests++;
      else dec_requests++;
      codec_predict(r);
   endtask

   task automatic send_text(input string s, input logic eom_last);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], eom_last && (i == s.len() - 1));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (exp_codec_out.size() != 0) @(posedge clock);
      // requests that make no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input logic dir);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = dir;
      do @(posedge clock); while (!csr_ready);
      dir_mode = dir;
      clear_group();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] pick_whitespace();
      case ($urandom_range(0, 3))
         0:       return CHAR_CR;
         1:       return CHAR_LF;
         2:       return CHAR_TAB;
         default: return CHAR_SP;
      endcase
   endfunction

   task automatic test_encode_directed();
      write_direction(DIR_ENCODE);
      send_text("Man", 1'b1);
      send_text("Ma", 1'b1);
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hFE, 1'b1);
      wait_idle();
   endtask

   task automatic test_decode_directed();
      write_direction(DIR_DECODE);
      send_text("T\015W\tF\nu", 1'b0);
      // pad at the front of a group
      send_text("=A+/", 1'b0);
      send_text("A===", 1'b0);
      send_text("z9", 1'b1);
      // unknown char, then a space that ends the message with nothing to give
      send_text("\200 ", 1'b1);
      wait_idle();
   endtask

   task automatic test_random_encode(input int count);
      int sent;
      int len;
      sent = 0;
      write_direction(DIR_ENCODE);
      while (sent < count) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            send_item(8'($urandom_range(0, 255)), i == len - 1);
            sent++;
         end
      end
      wait_idle();
   endtask

   task automatic test_input_backpressure(input int count);
      gaps_on = 1'b0;
      @(posedge clock);
      stall_hold = 200;
      for (int i = 0; i < count; i++)
         send_item(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
      gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic test_random_decode(input int count);
      int         sent;
      int         nbytes;
      int         left;
      logic [7:0] raw[$];
      logic [7:0] text[$];
      logic [23:0] g;
      sent = 0;
      write_direction(DIR_DECODE);
      while (sent < count) begin
         text.delete();
         if ($urandom_range(0, 4) != 0) begin
            // well-formed text from random bytes
            raw.delete();
            nbytes = $urandom_range(1, 7);
            for (int i = 0; i < nbytes; i++) raw.push_back(8'($urandom_range(0, 255)));
            for (int j = 0; j < nbytes; j += 3) begin
               left = nbytes - j;
               g = {raw[j], left > 1 ? raw[j + 1] : 8'h00, left > 2 ? raw[j + 2] : 8'h00};
               text.push_back(b64_char(g[23:18]));
               text.push_back(b64_char(g[17:12]));
               text.push_back(left > 1 ? b64_char(g[11:6]) : PAD_CHAR);
               text.push_back(left > 2 ? b64_char(g[5:0]) : PAD_CHAR);
            end
            // sometimes drop the padding so the end fills it in
            if ($urandom_range(0, 3) == 0)
               while (text[$] == PAD_CHAR) void'(text.pop_back());
         end else begin
            for (int i = 0; i < $urandom_range(1, 9); i++)
               text.push_back($urandom_range(0, 3) == 0 ? PAD_CHAR : 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 5) == 0) text.push_back(pick_whitespace());
         for (int i = 0; i < text.size(); i++) begin
            if ($urandom_range(0, 7) == 0) begin
               send_item(pick_whitespace(), 1'b0);
               sent++;
            end
            send_item(text[i], i == text.size() - 1);
            sent++;
         end
      end
      wait_idle();
   endtask

   task automatic test_direction_clears_group();
      // leave a decode group half full, then switch
      send_text("QU", 1'b0);
      wait_idle();
      write_direction(DIR_ENCODE);
      send_text("Hi", 1'b1);
      wait_idle();
      write_direction(DIR_DECODE);
      send_text("SGk", 1'b1);
      wait_idle();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_data    = 1'b0;
      dir_mode    = DIR_ENCODE;
      clear_group();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_encode_directed();
      test_decode_directed();
      test_random_encode(45);
      test_input_backpressure(24);
      test_random_decode(50);
      test_direction_clears_group();

      $display("ran %0d encode and %0d decode requests, %0d results checked",
               enc_requests, dec_requests, checked_results);
      $display("covered padding, whitespace, short groups, end markers and output hold-off");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // receiver stall pattern, with a long hold when a test asks for one
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall = 1'b1;
         stall_hold--;
      end else begin
         if (stall_phase == 0) begin
            stall_mode  = stall_mode_type'($urandom_range(0, 3));
            stall_phase = $urandom_range(20, 80);
         end
         stall_phase--;
         case (stall_mode)
            STALL_NONE:  rsp_stall = 1'b0;
            STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall = ($urandom_range(0, 9) < 6);
            default:     rsp_stall = (cycle_count % 3 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_codec_out.size() == 0) begin
            $display("%0t: unexpected result byte %h data %b last %b done %b", $time,
                     rsp_payload.out_byte, rsp_payload.has_data,
                     rsp_payload.last_of_run, rsp_payload.message_done);
            error_count++;
         end else begin
            want = exp_codec_out.pop_front();
            checked_results++;
            if (rsp_payload.out_byte !== want.out_byte ||
                rsp_payload.has_data !== want.has_data ||
                rsp_payload.last_of_run !== want.last_of_run ||
                rsp_payload.message_done !== want.message_done) begin
               $display({"%0t: mismatch, expected byte %h data %b last %b done %b,",
                         " got byte %h data %b last %b done %b"},
                        $time, want.out_byte, want.has_data, want.last_of_run,
                        want.message_done, rsp_payload.out_byte, rsp_payload.has_data,
                        rsp_payload.last_of_run, rsp_payload.message_done);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               exp_codec_out.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
